// ===== hw/rtl/sem_pkg.sv =====
// Package for the Sobel edge magnitude unit: sizes, state types and the
// queue entry that links the window front end to the magnitude back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
  localparam int FW_BITS    = 11;
  localparam int FH_BITS    = 13;
  localparam int CFG_BITS   = 13;
  localparam int QDEPTH     = 2;
  localparam int SAT_LIMIT  = 65280;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic [8:0][23:0] win;       // index = column * 3 + row, masked
    logic             frame_end;
  } entry_t;

  typedef enum logic {F_IDLE, F_LOAD} fstate_t;
  typedef enum logic [2:0] {B_IDLE, B_SQ, B_ROOT, B_ROUND, B_OUT} bstate_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sem_front.sv =====
// Front end: position counters, the two line stores and the 3x3 window.
// Pushes masked windows into the queue. Depends on sem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sem_front import sem_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [FW_BITS-1:0] frame_width,
  input  wire logic [FH_BITS-1:0] frame_height,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               kind,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  output logic                    q_push,
  input  wire logic               q_full,
  output entry_t                  q_data
);
  fstate_t state, state_next;
  pix_t older_mem [MAX_WIDTH];
  pix_t newer_mem [MAX_WIDTH];
  pix_t top_q, mid_q;
  pix_t win [9];
  pix_t win_next [9];
  logic [FW_BITS-1:0] col;
  logic [FH_BITS-1:0] row;
  pix_t ld_pix;
  logic [ADDR_BITS-1:0] ld_addr;
  logic ld_emit, ld_fe;
  logic [3:0] ld_keep;   // top, bottom, left, right

  logic [FW_BITS-1:0] w_eff, c1, c2, ocol;
  logic [FH_BITS:0]   h_eff, r1, r2, orow;
  logic valid, emit, fe, ignore, accept, advance;
  logic [3:0] keep;

  always_comb begin
    if (frame_width == '0) w_eff = FW_BITS'(1);
    else if (frame_width > FW_BITS'(MAX_WIDTH)) w_eff = FW_BITS'(MAX_WIDTH);
    else w_eff = frame_width;
    if (frame_height == '0) h_eff = (FH_BITS+1)'(1);
    else if (frame_height > FH_BITS'(MAX_HEIGHT)) h_eff = (FH_BITS+1)'(MAX_HEIGHT);
    else h_eff = {1'b0, frame_height};
  end

  always_comb begin
    c1 = col;
    r1 = {1'b0, row};
    if (c1 >= w_eff) begin
      c1 = '0;
      r1 = r1 + 1'b1;
    end
    if (r1 > h_eff + 1'b1) begin
      c1 = '0;
      r1 = '0;
    end
    if (c1 != '0) begin
      valid = r1 >= (FH_BITS+1)'(1);
      orow  = r1 - 1'b1;
      ocol  = c1 - 1'b1;
    end else begin
      valid = r1 >= (FH_BITS+1)'(2);
      orow  = r1 - (FH_BITS+1)'(2);
      ocol  = w_eff - 1'b1;
    end
    c2 = c1 + 1'b1;
    r2 = r1;
    if (c2 >= w_eff) begin
      c2 = '0;
      r2 = r1 + 1'b1;
    end
    emit = valid && (orow < h_eff);
    keep = {orow != '0, orow != h_eff - 1'b1, ocol != '0, ocol != w_eff - 1'b1};
    fe   = emit && (orow == h_eff - 1'b1) && (ocol == w_eff - 1'b1);
  end

  // A flush tick with both counters at zero is taken and dropped.
  assign ignore  = kind && (col == '0) && (row == '0);
  assign accept  = push && !full;
  assign advance = (state == F_LOAD) && (!ld_emit || !q_full);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept && !ignore) state_next = F_LOAD;
      F_LOAD: if (advance) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != F_IDLE);
    q_push = (state == F_LOAD) && ld_emit && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      if (accept && !ignore) begin
        if (fe) begin
          col <= '0;
          row <= '0;
        end else begin
          col <= c2;
          row <= r2[FH_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      top_q   <= older_mem[c1[ADDR_BITS-1:0]];
      mid_q   <= newer_mem[c1[ADDR_BITS-1:0]];
      ld_addr <= c1[ADDR_BITS-1:0];
      ld_pix  <= kind ? '0 : {in_red, in_green, in_blue};
      ld_emit <= emit;
      ld_fe   <= fe;
      ld_keep <= keep;
    end
    if (advance) begin
      older_mem[ld_addr] <= mid_q;
      newer_mem[ld_addr] <= ld_pix;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) win_next[i] = win[i+3];
    win_next[6] = top_q;
    win_next[7] = mid_q;
    win_next[8] = ld_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (advance) begin
      for (int i = 0; i < 9; i++) win[i] <= win_next[i];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        if ((r == 0 && !ld_keep[3]) || (r == 2 && !ld_keep[2]) ||
            (k == 0 && !ld_keep[1]) || (k == 2 && !ld_keep[0]))
          q_data.win[k*3+r] = '0;
        else
          q_data.win[k*3+r] = win_next[k*3+r];
      end
    end
    q_data.frame_end = ld_fe;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sem_queue.sv =====
// Short queue of masked windows between the front and back ends.
// Depends on sem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sem_queue import sem_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr,
  input  wire entry_t wdata,
  output logic        q_full,
  input  wire logic   rd,
  output entry_t      rdata,
  output logic        q_empty
);
  localparam int PB = $clog2(QDEPTH);
  entry_t slots [QDEPTH];
  logic [PB-1:0] wp, rp;
  logic [PB:0]   cnt;

  assign q_full  = (cnt == (PB+1)'(QDEPTH));
  assign q_empty = (cnt == '0);
  assign rdata   = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !q_full) wp <= (wp == PB'(QDEPTH-1)) ? '0 : wp + 1'b1;
      if (rd && !q_empty) rp <= (rp == PB'(QDEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PB+1)'(wr && !q_full) - (PB+1)'(rd && !q_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !q_full) slots[wp] <= wdata;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sem_back.sv =====
// Back end: Sobel gradients, sum of squares and a bit-serial integer root
// with rounding and saturation, three channels in parallel lanes. Depends on sem_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sem_back import sem_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire entry_t q_data,
  input  wire logic   q_empty,
  output logic        q_pop,
  output logic        empty,
  input  wire logic   pop,
  output logic [7:0]  edge_red,
  output logic [7:0]  edge_green,
  output logic [7:0]  edge_blue,
  output logic        frame_end
);
  bstate_t state, state_next;
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  logic signed [11:0] gx_c [3];
  logic signed [11:0] gy_c [3];
  logic [21:0] s [3];
  logic [10:0] rem [3];
  logic [7:0]  q [3];
  logic [7:0]  res [3];
  logic [2:0]  step;
  logic        fe;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [11:0] p [9];
      for (int i = 0; i < 9; i++)
        p[i] = $signed({4'b0, q_data.win[i][(16-8*ch) +: 8]});
      // p index is column * 3 + row
      gx_c[ch] = -p[0] + p[6] - 12'sd2 * p[1] + 12'sd2 * p[7] - p[2] + p[8];
      gy_c[ch] = -p[0] - 12'sd2 * p[3] - p[6] + p[2] + 12'sd2 * p[5] + p[8];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_SQ;
      B_SQ:    state_next = B_ROOT;
      B_ROOT:  if (step == '0) state_next = B_ROUND;
      B_ROUND: state_next = B_OUT;
      B_OUT:   if (pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    empty = (state != B_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        for (int ch = 0; ch < 3; ch++) begin
          gx[ch] <= gx_c[ch];
          gy[ch] <= gy_c[ch];
        end
        fe <= q_data.frame_end;
      end
      B_SQ: begin
        // The gradients are widened first so that the squares keep all their bits.
        for (int ch = 0; ch < 3; ch++) begin
          s[ch]   <= 22'($unsigned(22'(gx[ch]) * 22'(gx[ch])))
                   + 22'($unsigned(22'(gy[ch]) * 22'(gy[ch])));
          rem[ch] <= '0;
          q[ch]   <= '0;
        end
        step <= 3'd7;
      end
      B_ROOT: begin
        // One root bit per cycle, two bits of the radicand brought down.
        for (int ch = 0; ch < 3; ch++) begin
          logic [10:0] r4;
          logic [10:0] trial;
          r4    = {rem[ch][8:0], s[ch][2*step+1 -: 2]};
          trial = {1'b0, q[ch], 2'b01};
          if (r4 >= trial) begin
            rem[ch] <= r4 - trial;
            q[ch]   <= {q[ch][6:0], 1'b1};
          end else begin
            rem[ch] <= r4;
            q[ch]   <= {q[ch][6:0], 1'b0};
          end
        end
        step <= step - 1'b1;
      end
      B_ROUND: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (s[ch] > 22'(SAT_LIMIT)) res[ch] <= 8'd255;
          else if (rem[ch] > {3'b0, q[ch]} && q[ch] != 8'd255) res[ch] <= q[ch] + 1'b1;
          else res[ch] <= q[ch];
        end
      end
      B_OUT: ;
      default: ;
    endcase
  end

  assign edge_red   = res[0];
  assign edge_green = res[1];
  assign edge_blue  = res[2];
  assign frame_end  = fe;
endmodule
`default_nettype wire

// ===== hw/rtl/sobel_edge_magnitude_rgb_unit.sv =====
// Sobel edge magnitude on an RGB raster stream. In the front end each input
// transfer is a line-store read, then the store write and window shift, which
// may wait on a full queue. In the back end each result goes through take,
// square, the eight-step root, round, then hold until popped; a result leaves
// frame_width + 1 items after its pixel, up to two queued. Synchronous reset
// clears counters, window, queue and handshake state; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_rgb_unit import sem_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                kind,
  input  wire logic [7:0]          in_red,
  input  wire logic [7:0]          in_green,
  input  wire logic [7:0]          in_blue,
  output logic                     empty,
  input  wire logic                pop,
  output logic [7:0]               edge_red,
  output logic [7:0]               edge_green,
  output logic [7:0]               edge_blue,
  output logic                     frame_end
);
  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  entry_t wdata, rdata;
  logic q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_BITS'(1024);
      frame_height <= FH_BITS'(1024);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH:  frame_width  <= cfg_data[FW_BITS-1:0];
        CFG_HEIGHT: frame_height <= cfg_data[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  sem_front u_front (
    .clk, .rst, .frame_width, .frame_height, .push, .full, .kind,
    .in_red, .in_green, .in_blue, .q_push, .q_full, .q_data(wdata)
  );

  sem_queue u_queue (
    .clk, .rst, .wr(q_push), .wdata, .q_full, .rd(q_pop), .rdata, .q_empty
  );

  sem_back u_back (
    .clk, .rst, .q_data(rdata), .q_empty, .q_pop, .empty, .pop,
    .edge_red, .edge_green, .edge_blue, .frame_end
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("window queue overflow");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(edge_red) && $stable(edge_green)
    && $stable(edge_blue) && $stable(frame_end))) else $error("result changed while waiting");
  a_pop_only_ready: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue read while empty");
`endif
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for sobel_edge_magnitude_rgb_unit: directed frames, then
// random frames, checked against an in-bench Sobel predictor.
// Depends on sem_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb;
  import sem_pkg::*;

  typedef struct {
    logic [7:0] red, green, blue;
    logic       fe;
  } edge_t;

  typedef enum {OP_CFG_W, OP_CFG_H, OP_ITEM, OP_DRAIN} op_e;

  typedef struct {
    op_e         op;
    int          arg;     // register value, or kind for an item
    logic [23:0] rgb;
    bit          typed;
    edge_t       want;
  } row_t;

  logic clk = 0, rst = 1;
  logic cfg_write = 0, cfg_index = 0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic push = 0, kind = 0, pop = 0;
  logic [7:0] in_red = 0, in_green = 0, in_blue = 0;
  logic full, empty, frame_end;
  logic [7:0] edge_red, edge_green, edge_blue;

  sobel_edge_magnitude_rgb_unit dut (.*);

  // Predictor state.
  logic [23:0] older_line [MAX_WIDTH];
  logic [23:0] newer_line [MAX_WIDTH];
  logic [23:0] win [9];
  int col_pos = 0, row_pos = 0;
  logic [FW_BITS-1:0] width_reg = 1024;
  logic [FH_BITS-1:0] height_reg = 1024;

  edge_t pending_edges [$];
  int errors = 0;
  int sent = 0;
  bit typed_now = 0;
  edge_t typed_want;
  bit hold_req = 0;

  row_t dir_rows [20] = '{
    '{OP_CFG_W, 0, 0, 0, '{0, 0, 0, 0}},
    '{OP_CFG_H, 0, 0, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'hff0080, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 1, 0, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 1, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{OP_DRAIN, 0, 0, 0, '{0, 0, 0, 0}},
    '{OP_CFG_W, 3, 0, 0, '{0, 0, 0, 0}},
    '{OP_CFG_H, 3, 0, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'h000000, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'h80fe01, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'h000000, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'hff00ff, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'hffffff, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'h00ff00, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 1, 0, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'h7f7f7f, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'hffffff, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 1, 0, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 0, 24'hffffff, 0, '{0, 0, 0, 0}},
    '{OP_ITEM, 1, 0, 0, '{0, 0, 0, 0}}
  };

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 3_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // Rounded root of gx^2 + gy^2, saturated at 255.
  function automatic logic [7:0] grad_mag(int gx, int gy);
    int s, q;
    s = gx * gx + gy * gy;
    if (s > SAT_LIMIT) return 8'd255;
    q = 0;
    while ((q + 1) * (q + 1) <= s) q++;
    if (s - q * q > q) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic bit sobel_step(bit flush, logic [23:0] px, output edge_t res);
    int w, h, c, orow, ocol, sh, gx, gy;
    logic [23:0] pix, top, mid;
    bit valid;
    bit keep_r [3];
    bit keep_c [3];
    int p [3][3];
    logic [7:0] mags [3];
    w = eff_width();
    h = eff_height();
    res = '{0, 0, 0, 0};
    if (flush && col_pos == 0 && row_pos == 0) return 0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    pix = flush ? 24'd0 : px;
    c = col_pos % MAX_WIDTH;
    top = older_line[c];
    mid = newer_line[c];
    older_line[c] = mid;
    newer_line[c] = pix;
    for (int i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = top;
    win[7] = mid;
    win[8] = pix;
    if (col_pos >= 1) begin
      valid = row_pos >= 1;
      orow = row_pos - 1;
      ocol = col_pos - 1;
    end else begin
      valid = row_pos >= 2;
      orow = row_pos - 2;
      ocol = w - 1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!valid || orow >= h) return 0;
    keep_r = '{orow != 0, 1'b1, orow != h - 1};
    keep_c = '{ocol != 0, 1'b1, ocol != w - 1};
    for (int ch = 0; ch < 3; ch++) begin
      sh = 16 - 8 * ch;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          p[r][k] = (keep_r[r] && keep_c[k]) ? int'((win[k * 3 + r] >> sh) & 8'hff) : 0;
      gx = -p[0][0] + p[0][2] - 2 * p[1][0] + 2 * p[1][2] - p[2][0] + p[2][2];
      gy = -p[0][0] - 2 * p[0][1] - p[0][2] + p[2][0] + 2 * p[2][1] + p[2][2];
      mags[ch] = grad_mag(gx, gy);
    end
    res.red = mags[0];
    res.green = mags[1];
    res.blue = mags[2];
    if (orow == h - 1 && ocol == w - 1) begin
      res.fe = 1;
      col_pos = 0;
      row_pos = 0;
    end
    return 1;
  endfunction

  // Input side: predict on every accepted transfer; result side: check.
  always @(posedge clk) begin
    edge_t res, want;
    if (!rst && push && !full) begin
      sent++;
      if (sobel_step(kind, {in_red, in_green, in_blue}, res))
        pending_edges.push_back(typed_now ? typed_want : res);
    end
    if (!rst && pop && !empty) begin
      if (pending_edges.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = pending_edges.pop_front();
        if (edge_red !== want.red) begin
          $error("edge_red: expected %0d, got %0d", want.red, edge_red);
          errors++;
        end
        if (edge_green !== want.green) begin
          $error("edge_green: expected %0d, got %0d", want.green, edge_green);
          errors++;
        end
        if (edge_blue !== want.blue) begin
          $error("edge_blue: expected %0d, got %0d", want.blue, edge_blue);
          errors++;
        end
        if (frame_end !== want.fe) begin
          $error("frame_end: expected %0d, got %0d", want.fe, frame_end);
          errors++;
        end
      end
    end
  end

  // Receiver: changing pop patterns, plus one long hold-off on request.
  int hold_left = 0, pat_left = 0, pat = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 0;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(8, 80);
        pat = $urandom_range(0, 3);
      end
      pat_left--;
      case (pat)
        0: pop <= 1;
        1: pop <= $urandom_range(0, 1);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_item(bit k, logic [23:0] rgb, bit typed, edge_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push = 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push = 1;
    kind = k;
    {in_red, in_green, in_blue} = rgb;
    typed_now = typed;
    typed_want = want;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    push = 0;
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = CFG_BITS'(val);
    @(negedge clk);
    cfg_write = 0;
    if (idx == CFG_WIDTH) width_reg = FW_BITS'(val);
    else height_reg = FH_BITS'(val);
  endtask

  // Idle the sender until all results are out, then let the back end settle.
  task automatic drain();
    push = 0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_frame(int w, int h, bit noisy);
    int ew;
    edge_t none;
    none = '{0, 0, 0, 0};
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    ew = eff_width();
    for (int i = 0; i < ew * eff_height(); i++) begin
      // A flush tick mid frame stands in for a zero pixel.
      if (noisy && $urandom_range(0, 19) == 0) send_item(1, 0, 0, none);
      else send_item(0, {rand_sample(), rand_sample(), rand_sample()}, 0, none);
    end
    for (int i = 0; i <= ew; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item(0, {rand_sample(), rand_sample(), rand_sample()}, 0, none);
      else
        send_item(1, 0, 0, none);
    end
    if (noisy && $urandom_range(0, 3) == 0) send_item(1, 0, 0, none);
  endtask

  initial begin
    int w, h, frames;
    for (int i = 0; i < 9; i++) win[i] = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_line[i] = 0;
      newer_line[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        OP_CFG_W: write_reg(CFG_WIDTH, dir_rows[i].arg);
        OP_CFG_H: write_reg(CFG_HEIGHT, dir_rows[i].arg);
        OP_DRAIN: drain();
        default: send_item(dir_rows[i].arg, dir_rows[i].rgb, dir_rows[i].typed,
                           dir_rows[i].want);
      endcase
    end

    // Zero register values on both sides, and a single-row frame.
    run_frame(0, 3, 0);
    run_frame(4, 0, 0);
    run_frame(5, 1, 0);

    frames = 0;
    while (sent < 480) begin
      case ($urandom_range(0, 9))
        0: begin w = $urandom_range(0, 1) ? 0 : 1; h = $urandom_range(1, 6); end
        1: begin w = $urandom_range(2, 8); h = $urandom_range(0, 1) ? 0 : 1; end
        default: begin w = $urandom_range(2, 9); h = $urandom_range(2, 7); end
      endcase
      if (frames == 0 || $urandom_range(0, 7) == 0) hold_req = 1;
      run_frame(w, h, 1);
      frames++;
    end

    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
